/* rtl/core/kped_pkg.sv */
// ============================================================================
// Key press event detector package
// Shared types and constants for the debounce and press state machine.
// ============================================================================
package kped_pkg;

    localparam int unsigned ACC_W     = 16;
    localparam int unsigned STEP_W    = 8;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DAT_W = 16;

    localparam logic [ACC_W-1:0] ACC_MAX = '1;

    // Key phase codes; the released kinds sit three above their held kinds.
    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_PRESS     = 3'd1,
        PH_LONG      = 3'd2,
        PH_REPEAT    = 3'd3,
        PH_PRESS_UP  = 3'd4,
        PH_LONG_UP   = 3'd5,
        PH_REPEAT_UP = 3'd6
    } phase_t;

    // Event codes; an event always names the phase it moves into.
    typedef enum logic [2:0] {
        EV_NONE       = 3'd0,
        EV_PRESS      = 3'd1,
        EV_LONG       = 3'd2,
        EV_REPEAT     = 3'd3,
        EV_PRESS_REL  = 3'd4,
        EV_LONG_REL   = 3'd5,
        EV_REPEAT_REL = 3'd6
    } event_t;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ACTIVE_LEVEL   = 3'd0,
        CFG_SCAN_STEP      = 3'd1,
        CFG_DEBOUNCE_LIMIT = 3'd2,
        CFG_LONG_LIMIT     = 3'd3,
        CFG_REPEAT_LIMIT   = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic              active_level;
        logic [STEP_W-1:0] scan_step;
        logic [ACC_W-1:0]  debounce_limit;
        logic [ACC_W-1:0]  long_limit;
        logic [ACC_W-1:0]  repeat_limit;
    } cfg_t;

    typedef struct packed {
        phase_t           phase;
        logic             stable_level;
        logic [ACC_W-1:0] debounce_acc;
        logic [ACC_W-1:0] hold_acc;
    } key_state_t;

    function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0]  acc,
                                                 input logic [STEP_W-1:0] step);
        logic [ACC_W:0] sum;
        sum = {1'b0, acc} + {{(ACC_W + 1 - STEP_W){1'b0}}, step};
        sat_add = sum[ACC_W] ? ACC_MAX : sum[ACC_W-1:0];
    endfunction

endpackage

/* rtl/core/kped_step.sv */
// ============================================================================
// Key press event detector step logic
// Works out the next key state and the event for one sampled level.
// ============================================================================
module kped_step
    import kped_pkg::*;
(
    input  logic       level,
    input  cfg_t       cfg,
    input  key_state_t cur,
    output key_state_t nxt,
    output event_t     ev
);

    logic             run;
    logic             active;
    logic [ACC_W-1:0] hold_sum;
    logic [ACC_W-1:0] hold_lim;
    phase_t           phase_run;

    assign active   = (level == cfg.active_level);
    assign hold_sum = sat_add(cur.hold_acc, cfg.scan_step);
    assign hold_lim = (cur.phase == PH_PRESS) ? cfg.long_limit : cfg.repeat_limit;

    always_comb begin
        nxt       = cur;
        run       = 1'b1;
        phase_run = cur.phase;
        ev        = EV_NONE;
        if (level != cur.stable_level) begin
            if (cur.debounce_acc < cfg.debounce_limit) begin
                nxt.debounce_acc = sat_add(cur.debounce_acc, cfg.scan_step);
                run = 1'b0;
            end else begin
                nxt.stable_level = level;
                nxt.debounce_acc = '0;
            end
        end
        case (cur.phase)
            PH_PRESS, PH_LONG, PH_REPEAT: begin
                if (active) begin
                    nxt.hold_acc = hold_sum;
                    if (hold_sum >= hold_lim) begin
                        nxt.hold_acc = '0;
                        phase_run    = (cur.phase == PH_PRESS) ? PH_LONG : PH_REPEAT;
                        ev           = event_t'(phase_run);
                    end
                end else begin
                    nxt.hold_acc = '0;
                    case (cur.phase)
                        PH_PRESS: phase_run = PH_PRESS_UP;
                        PH_LONG:  phase_run = PH_LONG_UP;
                        default:  phase_run = PH_REPEAT_UP;
                    endcase
                    ev = event_t'(phase_run);
                end
            end
            default: begin
                // Idle, the released kinds and the unused code all behave as idle.
                if (active) begin
                    phase_run = PH_PRESS;
                    ev        = EV_PRESS;
                end
            end
        endcase
        if (run) begin
            nxt.phase = phase_run;
        end else begin
            nxt.hold_acc = cur.hold_acc;
            ev           = EV_NONE;
        end
    end

endmodule

/* rtl/core/key_press_event_detector.sv */
// ============================================================================
// Key press event detector
// Debounces a sampled key level and reports press, long and repeat events.
// ============================================================================
// Each input item is one scan tick carrying the raw key level in s_tdata[0].
// Each tick yields exactly one result item on the m_ channel: the event code,
// the key phase after the tick and the debounced level. Event code zero means
// that nothing happened on that tick; ticks spent debouncing a changed level
// always give event zero.
// The block is a two-stage pipeline: the tick is captured in an input
// register, and once the result register is free or being emptied the step
// logic updates the key state and loads the result register. One item is
// accepted every cycle while the receiver does not stall.
// When the receiver stalls, the result register holds its item and the input
// register takes one more item before s_tready falls; nothing is dropped.
// Reset (aresetn low, synchronous) empties both registers, returns the key to
// idle with a released (high) stable level and both accumulators cleared, and
// loads the configuration registers with their defaults. Configuration must be
// written through cfg_wr_en / cfg_index / cfg_wdata while the block is idle;
// the block does not enforce it. Indexes beyond the register list are ignored.
// ============================================================================
module key_press_event_detector
    import kped_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [0] key_level, [7:1] zero
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata,   // [2:0] event_res, [5:3] key_phase,
                                            // [6] stable_out, [7] zero
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_wdata
);

    // Configuration registers.
    cfg_t       cfg_reg;

    // Input register stage.
    logic       in_valid_reg;
    logic       in_level_reg;

    // Key state, updated once per tick as it leaves the input register.
    key_state_t state_reg;
    key_state_t state_next;
    event_t     ev_next;

    // Result register stage.
    logic       out_valid_reg;
    event_t     out_event_reg;
    phase_t     out_phase_reg;
    logic       out_stable_reg;

    logic       advance;

    // The tick moves on when there is one and the result register is free
    // or is being emptied in this cycle.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.active_level   <= 1'b0;
            cfg_reg.scan_step      <= STEP_W'(10);
            cfg_reg.debounce_limit <= ACC_W'(20);
            cfg_reg.long_limit     <= ACC_W'(1000);
            cfg_reg.repeat_limit   <= ACC_W'(200);
        end else if (cfg_wr_en) begin
            case (cfg_idx_t'(cfg_index))
                CFG_ACTIVE_LEVEL:   cfg_reg.active_level   <= cfg_wdata[0];
                CFG_SCAN_STEP:      cfg_reg.scan_step      <= cfg_wdata[STEP_W-1:0];
                CFG_DEBOUNCE_LIMIT: cfg_reg.debounce_limit <= cfg_wdata[ACC_W-1:0];
                CFG_LONG_LIMIT:     cfg_reg.long_limit     <= cfg_wdata[ACC_W-1:0];
                CFG_REPEAT_LIMIT:   cfg_reg.repeat_limit   <= cfg_wdata[ACC_W-1:0];
                default: ;
            endcase
        end
    end

    // Input register: a new tick is captured whenever s_tready and s_tvalid are high.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_level_reg <= s_tdata[0];
        end
    end

    kped_step u_step (
        .level (in_level_reg),
        .cfg   (cfg_reg),
        .cur   (state_reg),
        .nxt   (state_next),
        .ev    (ev_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.phase        <= PH_IDLE;
            state_reg.stable_level <= 1'b1;
            state_reg.debounce_acc <= '0;
            state_reg.hold_acc     <= '0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // Result register: filled when a tick advances, emptied when taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_event_reg  <= ev_next;
            out_phase_reg  <= state_next.phase;
            out_stable_reg <= state_next.stable_level;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_stable_reg, out_phase_reg, out_event_reg};

endmodule

/* dv/tb_top.sv */
// ----------------------------------------------------------------------------
// Testbench for the key press event detector
// Drives scan ticks with random gaps against a randomly stalling receiver.
// A scoreboard class predicts each result item and checks the block's output.
// ----------------------------------------------------------------------------
module tb_top;
    import kped_pkg::*;

    // The run is cut short here if the block stops producing results.
    localparam int CYCLE_LIMIT = 200000;
    // Cycles allowed after the last result for the pipeline to settle.
    localparam int SETTLE_CYCLES = 4;

    // One predicted result item, its fields listed in the order they sit in m_tdata from bit 0 up.
    typedef struct packed {
        event_t ev;
        phase_t ph;
        logic   stable;
    } tick_result_t;

    // The scoreboard keeps its own copy of the registers and of the key
    // state, works out the result of every accepted tick and checks the
    // block's results against those predictions in order.
    class key_event_scoreboard;
        cfg_t         regs;
        key_state_t   key;
        tick_result_t outcomes[$];
        int           errors;

        function new();
            regs.active_level   = 1'b0;
            regs.scan_step      = 8'd10;
            regs.debounce_limit = 16'd20;
            regs.long_limit     = 16'd1000;
            regs.repeat_limit   = 16'd200;
            key.phase           = PH_IDLE;
            key.stable_level    = 1'b1;
            key.debounce_acc    = '0;
            key.hold_acc        = '0;
            errors              = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
            case (idx)
                CFG_ACTIVE_LEVEL:   regs.active_level   = val[0];
                CFG_SCAN_STEP:      regs.scan_step      = val[STEP_W-1:0];
                CFG_DEBOUNCE_LIMIT: regs.debounce_limit = val;
                CFG_LONG_LIMIT:     regs.long_limit     = val;
                CFG_REPEAT_LIMIT:   regs.repeat_limit   = val;
                default: ;
            endcase
        endfunction

        // Accumulators stop at their top value instead of wrapping.
        function logic [ACC_W-1:0] grow(logic [ACC_W-1:0] acc);
            logic [ACC_W:0] total;
            total = {1'b0, acc} + (ACC_W + 1)'(regs.scan_step);
            return total[ACC_W] ? {ACC_W{1'b1}} : total[ACC_W-1:0];
        endfunction

        function void note_tick(logic level);
            tick_result_t     res;
            logic             settled;
            logic [ACC_W-1:0] limit;
            res.ev  = EV_NONE;
            settled = 1'b1;
            // A changed level only counts once enough differing ticks have added up.
            if (level != key.stable_level) begin
                if (key.debounce_acc < regs.debounce_limit) begin
                    key.debounce_acc = grow(key.debounce_acc);
                    settled          = 1'b0;
                end else begin
                    key.stable_level = level;
                    key.debounce_acc = '0;
                end
            end
            if (settled) begin
                if (key.phase == PH_PRESS || key.phase == PH_LONG ||
                    key.phase == PH_REPEAT) begin
                    if (level == regs.active_level) begin
                        limit = (key.phase == PH_PRESS) ? regs.long_limit
                                                        : regs.repeat_limit;
                        key.hold_acc = grow(key.hold_acc);
                        if (key.hold_acc >= limit) begin
                            key.hold_acc = '0;
                            if (key.phase == PH_PRESS) begin
                                key.phase = PH_LONG;
                                res.ev    = EV_LONG;
                            end else begin
                                key.phase = PH_REPEAT;
                                res.ev    = EV_REPEAT;
                            end
                        end
                    end else begin
                        key.hold_acc = '0;
                        case (key.phase)
                            PH_PRESS: begin
                                key.phase = PH_PRESS_UP;
                                res.ev    = EV_PRESS_REL;
                            end
                            PH_LONG: begin
                                key.phase = PH_LONG_UP;
                                res.ev    = EV_LONG_REL;
                            end
                            default: begin
                                key.phase = PH_REPEAT_UP;
                                res.ev    = EV_REPEAT_REL;
                            end
                        endcase
                    end
                end else if (level == regs.active_level) begin
                    key.phase = PH_PRESS;
                    res.ev    = EV_PRESS;
                end
            end
            res.ph     = key.phase;
            res.stable = key.stable_level;
            outcomes.push_back(res);
        endfunction

        function void check_result(logic [7:0] data);
            tick_result_t want;
            if (outcomes.size() == 0) begin
                $display("%0t: unexpected result item %h", $time, data);
                errors++;
                return;
            end
            want = outcomes.pop_front();
            if (data[2:0] !== want.ev) begin
                $display("%0t: event expected %0d, got %0d", $time, want.ev, data[2:0]);
                errors++;
            end
            if (data[5:3] !== want.ph) begin
                $display("%0t: phase expected %0d, got %0d", $time, want.ph, data[5:3]);
                errors++;
            end
            if (data[6] !== want.stable) begin
                $display("%0t: stable level expected %0d, got %0d",
                         $time, want.stable, data[6]);
                errors++;
            end
        endfunction

        function int pending();
            return outcomes.size();
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata   = '0;   // [0] key_level, [7:1] zero
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [7:0]           m_tdata;          // [2:0] event_res, [5:3] key_phase,
                                            // [6] stable_out, [7] zero
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_wdata = '0;

    key_event_scoreboard sb = new();

    // While calm is set neither side idles nor stalls.
    bit calm        = 1'b0;
    int cycle_count = 0;

    key_press_event_detector dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Watchdog: a hung block would otherwise leave the run going for ever.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Receiver: checks every accepted result item and stalls at random. The
    // values read here are those from before the edge, so the check never
    // depends on the order in which the block and this process run.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                sb.check_result(m_tdata);
            end
            m_tready <= calm || ($urandom_range(99) >= 24);
        end
    end

    // Offers one scan tick, after an occasional gap, and returns at the edge
    // where it is accepted. The valid is left high so that a following item
    // without a gap goes out on the very next cycle.
    task automatic send_tick(input logic lvl);
        int gap;
        gap = 0;
        if (!calm) begin
            while ($urandom_range(99) < 24 && gap < 6) gap++;
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, lvl};
        do @(posedge aclk); while (!s_tready);
        sb.note_tick(lvl);
    endtask

    task automatic send_run(input logic lvl, input int count);
        repeat (count) send_tick(lvl);
    endtask

    // Sends a fixed sequence of levels, bit 0 first.
    task automatic send_pattern(input logic [15:0] levels, input int count);
        for (int i = 0; i < count; i++) send_tick(levels[i]);
    endtask

    // Holds the sender back until every predicted result has arrived, then
    // waits out the settle time as well so that the block is truly idle.
    task automatic wait_for_results;
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DAT_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sb.write_reg(idx, val);
        @(posedge aclk);
    endtask

    task automatic set_keys(input logic act, input int step, input int deb,
                            input int lng, input int rep);
        write_reg(CFG_ACTIVE_LEVEL, CFG_DAT_W'(act));
        write_reg(CFG_SCAN_STEP, CFG_DAT_W'(step));
        write_reg(CFG_DEBOUNCE_LIMIT, CFG_DAT_W'(deb));
        write_reg(CFG_LONG_LIMIT, CFG_DAT_W'(lng));
        write_reg(CFG_REPEAT_LIMIT, CFG_DAT_W'(rep));
    endtask

    // Writes to an index beyond the register list must leave everything alone.
    task automatic write_stray;
        wait_for_results();
        write_reg(CFG_IDX_W'($urandom_range(2 ** CFG_IDX_W - 1, int'(CFG_REPEAT_LIMIT) + 1)),
                  CFG_DAT_W'($urandom));
    endtask

    // Rough number of ticks for an accumulator to reach a limit.
    function automatic int ticks_to(input int limit, input int step);
        return (step == 0) ? 2 : limit / step + 2;
    endfunction

    // One phase of random traffic. Most of it is well-formed key presses:
    // some contact bounce, a hold long enough to pass the debounce and often
    // the long and repeat thresholds, then a clean release. The rest is
    // random noise and presses that may be too short to survive the debounce.
    task automatic run_phase(input logic act, input int step, input int deb,
                             input int lng, input int rep, input int budget,
                             input bit quiet);
        int sent;
        int t_deb;
        int t_long;
        int t_rep;
        int hold;
        int bounces;
        int noise;
        wait_for_results();
        set_keys(act, step, deb, lng, rep);
        calm   = quiet;
        t_deb  = ticks_to(deb, step);
        t_long = ticks_to(lng, step);
        t_rep  = ticks_to(rep, step);
        sent   = 0;
        while (sent < budget) begin
            if ($urandom_range(99) < 10) begin
                noise = $urandom_range(1, 6);
                repeat (noise) send_tick(1'($urandom));
                sent += noise;
            end else begin
                bounces = $urandom_range(0, 3);
                repeat (bounces) begin
                    send_tick(act);
                    send_tick(~act);
                end
                if ($urandom_range(99) < 20) begin
                    hold = $urandom_range(1, t_deb + 1);
                end else begin
                    hold = t_deb + $urandom_range(1, t_long + 3 * t_rep + 2);
                end
                if (hold > 700) hold = 700;
                send_run(act, hold);
                send_run(~act, t_deb + $urandom_range(0, 4));
                sent += 2 * bounces + hold + t_deb;
            end
        end
        calm = 1'b0;
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // With the reset settings: a change that returns early keeps its
        // debounce time, then a press and a press release after debouncing.
        send_pattern(16'b000111000101, 12);

        // Zero limits with the largest step: a level change is taken at once,
        // long and repeat fire on the first held ticks, and every kind of
        // release is seen.
        wait_for_results();
        set_keys(1'b0, 255, 0, 0, 0);
        send_pattern(16'b10110010000, 11);

        // Random phases; the first one runs without any idling.
        run_phase(1'b0, 10, 20, 100, 40, 200, 1'b1);
        write_stray();
        run_phase(1'b1, 7, 0, 50, 0, 150, 1'b0);
        run_phase(1'b0, 1, 3, 12, 5, 150, 1'b0);
        // Largest limits with a step that does not divide them: the
        // accumulators can reach their limits only by saturating.
        write_stray();
        run_phase(1'b1, 254, 65535, 65535, 65535, 1, 1'b0);
        // A step of zero with zero limits.
        run_phase(1'b0, 0, 0, 0, 0, 80, 1'b0);
        run_phase(1'b1, 20, 60, 200, 60, 200, 1'b0);

        wait_for_results();
        repeat (2 * SETTLE_CYCLES) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
